// ===== rtl/gmcp_pkg.sv =====
// Shared constants for the grid minimum-cost-path block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gmcp_pkg;

  localparam int CELL_COST_W = 16;
  localparam int PATH_COST_W = 32;
  localparam int CFG_DATA_W  = 11;
  localparam int CFG_ADDR_W  = 1;

  localparam int DEF_MAX_COLS  = 1024;
  localparam int DEF_MAX_ROWS  = 1024;
  localparam int DEF_COST_BITS = 16;

  localparam logic [CFG_ADDR_W-1:0] REG_NUM_ROWS = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_NUM_COLS = 1'd1;

  localparam logic [PATH_COST_W-1:0] TOTAL_MAX = '1;

endpackage

`default_nettype wire

// ===== rtl/grid_min_cost_path.sv =====
// Grid minimum-cost-path engine: streamed cost grid in, bottom-right total out.
// Depends on gmcp_pkg.
//
// Takes one grid cell per cycle in row-major order while cell_stall is low
// and gives the saturated minimum path total (moves right, down, diagonal)
// after the last cell. Two stages: the first reads the previous row's total
// from a one-port-read, one-port-write row memory; the second adds the cost
// to the least existing neighbor and writes back, with a bypass when one
// column is configured. path_valid is registered and rises once the last
// cell has left the first stage. The next grid may stream in while a result
// waits; input stalls only when a second result is ready and the first has
// not been taken. Writing either size register restarts the grid.
`timescale 1ns / 1ps
`default_nettype none

module grid_min_cost_path
  import gmcp_pkg::*;
#(
  parameter int MAX_COLS  = DEF_MAX_COLS,
  parameter int MAX_ROWS  = DEF_MAX_ROWS,
  parameter int COST_BITS = DEF_COST_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   cell_valid,
  output logic                        cell_stall,
  input  wire logic [CELL_COST_W-1:0] cell_cost,
  output logic                        path_valid,
  input  wire logic                   path_stall,
  output logic [PATH_COST_W-1:0]      path_cost
);

  localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam logic [CELL_COST_W-1:0] COST_MASK = (COST_BITS >= CELL_COST_W) ?
      {CELL_COST_W{1'b1}} : CELL_COST_W'((64'd1 << COST_BITS) - 64'd1);

  logic [CFG_DATA_W-1:0] num_rows;
  logic [CFG_DATA_W-1:0] num_cols;
  logic [COL_W-1:0]      col_last;
  logic [ROW_W-1:0]      row_last;

  logic [COL_W-1:0] col_index;
  logic [ROW_W-1:0] row_index;

  logic [PATH_COST_W-1:0] row_totals [MAX_COLS];
  logic [PATH_COST_W-1:0] top_rd;

  logic                   s1_valid;
  logic [CELL_COST_W-1:0] s1_cost;
  logic [COL_W-1:0]       s1_col;
  logic                   s1_has_top;
  logic                   s1_has_left;
  logic                   s1_last;
  logic                   s1_fwd;

  logic [PATH_COST_W-1:0] left_total;
  logic [PATH_COST_W-1:0] diag_total;

  logic                   cell_xfer;
  logic                   s1_go;
  logic                   at_col_last;
  logic                   at_row_last;
  logic [PATH_COST_W-1:0] top;
  logic [PATH_COST_W-1:0] best;
  logic [PATH_COST_W:0]   sum;
  logic [PATH_COST_W-1:0] total;

  // effective last column / row (zero acts as one, oversize clamps)
  always_comb begin
    if (num_cols == '0) begin
      col_last = '0;
    end else if (32'(num_cols) > 32'(MAX_COLS)) begin
      col_last = COL_W'(MAX_COLS - 1);
    end else begin
      col_last = COL_W'(32'(num_cols) - 32'd1);
    end
    if (num_rows == '0) begin
      row_last = '0;
    end else if (32'(num_rows) > 32'(MAX_ROWS)) begin
      row_last = ROW_W'(MAX_ROWS - 1);
    end else begin
      row_last = ROW_W'(32'(num_rows) - 32'd1);
    end
  end

  assign at_col_last = (col_index == col_last);
  assign at_row_last = (row_index == row_last);

  assign s1_go      = s1_valid && !(s1_last && path_valid && path_stall);
  assign cell_stall = s1_valid && !s1_go;
  assign cell_xfer  = cell_valid && !cell_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows <= CFG_DATA_W'(1);
      num_cols <= CFG_DATA_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_addr)
        REG_NUM_ROWS: num_rows <= cfg_data;
        REG_NUM_COLS: num_cols <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      col_index <= '0;
      row_index <= '0;
    end else if (cell_xfer) begin
      if (at_col_last) begin
        col_index <= '0;
        row_index <= at_row_last ? '0 : row_index + ROW_W'(1);
      end else begin
        col_index <= col_index + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cell_xfer) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cell_xfer) begin
      s1_cost     <= cell_cost & COST_MASK;
      s1_col      <= col_index;
      s1_has_top  <= (row_index != '0);
      s1_has_left <= (col_index != '0);
      s1_last     <= at_col_last && at_row_last;
      s1_fwd      <= s1_valid && (s1_col == col_index);
      top_rd      <= row_totals[col_index];
    end
  end

  // neighbor select, add, saturate
  always_comb begin
    top = s1_fwd ? left_total : top_rd;
    if (s1_has_top && s1_has_left) begin
      best = (top < left_total) ? top : left_total;
      best = (diag_total < best) ? diag_total : best;
    end else if (s1_has_top) begin
      best = top;
    end else begin
      best = left_total;
    end
    sum = {1'b0, best} + {{(PATH_COST_W + 1 - CELL_COST_W){1'b0}}, s1_cost};
    if (!s1_has_top && !s1_has_left) begin
      total = PATH_COST_W'(s1_cost);
    end else if (sum[PATH_COST_W]) begin
      total = TOTAL_MAX;
    end else begin
      total = sum[PATH_COST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      row_totals[s1_col] <= total;
      left_total         <= total;
      diag_total         <= top;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      path_valid <= 1'b0;
    end else if (s1_go && s1_last) begin
      path_valid <= 1'b1;
    end else if (!path_stall) begin
      path_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last) begin
      path_cost <= total;
    end
  end

endmodule

`default_nettype wire

// ===== verif/tb_grid_min_cost_path.sv =====
// Self-checking testbench for grid_min_cost_path: streams cost grids of many
// shapes under random valid/stall traffic and checks every path total against
// an in-bench dynamic-programming predictor. Depends on gmcp_pkg and the RTL.
`timescale 1ns / 1ps

module tb_grid_min_cost_path;
  import gmcp_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned RANDOM_CELLS  = 150;
  localparam int          COL_IDX_W     = $clog2(DEF_MAX_COLS);

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_ADDR_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   cell_valid;
  logic                   cell_stall;
  logic [CELL_COST_W-1:0] cell_cost;
  logic                   path_valid;
  logic                   path_stall = 1'b0;
  logic [PATH_COST_W-1:0] path_cost;

  grid_min_cost_path u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .cell_valid (cell_valid),
    .cell_stall (cell_stall),
    .cell_cost  (cell_cost),
    .path_valid (path_valid),
    .path_stall (path_stall),
    .path_cost  (path_cost)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state
  logic [PATH_COST_W-1:0] row_sums [DEF_MAX_COLS];
  logic [PATH_COST_W-1:0] left_sum;
  logic [PATH_COST_W-1:0] diag_sum;
  int unsigned            next_row;
  int unsigned            next_col;
  logic [CFG_DATA_W-1:0]  rows_setting;
  logic [CFG_DATA_W-1:0]  cols_setting;

  logic [PATH_COST_W-1:0] expected_path_costs [$];
  int unsigned            fails;
  int unsigned            cells_sent;
  int unsigned            burst_left;
  bit                     gaps_on;
  int unsigned            hold_request;
  int unsigned            hold_left;
  int unsigned            stall_mode;
  int unsigned            stall_mode_left;

  function automatic void restart_grid();
    next_row = 0;
    next_col = 0;
    left_sum = '0;
    diag_sum = '0;
  endfunction

  function automatic void apply_setting(logic [CFG_ADDR_W-1:0] addr,
                                        logic [CFG_DATA_W-1:0] value);
    if (addr == REG_NUM_ROWS) begin
      rows_setting = value;
    end else begin
      cols_setting = value;
    end
    restart_grid();
  endfunction

  function automatic int unsigned grid_extent(logic [CFG_DATA_W-1:0] setting,
                                              int unsigned limit);
    if (setting == '0) return 1;
    if (32'(setting) > limit) return limit;
    return 32'(setting);
  endfunction

  function automatic int unsigned cells_per_grid();
    return grid_extent(rows_setting, DEF_MAX_ROWS) * grid_extent(cols_setting, DEF_MAX_COLS);
  endfunction

  // Returns 1 when the cell closes the grid; total then holds the path cost.
  function automatic bit accumulate_cell(input logic [CELL_COST_W-1:0] cost,
                                         output logic [PATH_COST_W-1:0] total);
    logic [PATH_COST_W-1:0] top;
    logic [PATH_COST_W-1:0] best;
    logic [PATH_COST_W:0]   wide;
    bit                     have;
    int unsigned            rows;
    int unsigned            cols;
    rows = grid_extent(rows_setting, DEF_MAX_ROWS);
    cols = grid_extent(cols_setting, DEF_MAX_COLS);
    top  = row_sums[COL_IDX_W'(next_col)];
    best = TOTAL_MAX;
    have = 1'b0;
    if (next_row > 0) begin
      best = top;
      have = 1'b1;
    end
    if (next_col > 0) begin
      if (!have || left_sum < best) best = left_sum;
      have = 1'b1;
    end
    if (next_row > 0 && next_col > 0 && diag_sum < best) best = diag_sum;
    if (have) begin
      wide  = {1'b0, best} + {{(PATH_COST_W + 1 - CELL_COST_W){1'b0}}, cost};
      total = wide[PATH_COST_W] ? TOTAL_MAX : wide[PATH_COST_W-1:0];
    end else begin
      total = PATH_COST_W'(cost);
    end
    diag_sum                        = top;
    row_sums[COL_IDX_W'(next_col)] = total;
    left_sum                        = total;
    if (next_row + 1 >= rows && next_col + 1 >= cols) begin
      restart_grid();
      return 1'b1;
    end
    if (next_col + 1 >= cols) begin
      next_col = 0;
      next_row++;
    end else begin
      next_col++;
    end
    return 1'b0;
  endfunction

  function automatic logic [CELL_COST_W-1:0] random_cost();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2, 3: return CELL_COST_W'($urandom_range(0, 15));
      default: return CELL_COST_W'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_extent();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return CFG_DATA_W'($urandom_range(7, 12));
      default: return CFG_DATA_W'($urandom_range(1, 6));
    endcase
  endfunction

  // One cell transfer; valid stays high for a following cell in the burst.
  task automatic send_cell(input logic [CELL_COST_W-1:0] cost);
    logic [PATH_COST_W-1:0] total;
    int unsigned            gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on) begin
        gap = $urandom_range(1, 6);
        cell_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    cell_valid <= 1'b1;
    cell_cost  <= cost;
    do @(posedge clk); while (cell_stall !== 1'b0);
    cells_sent++;
    if (accumulate_cell(cost, total)) expected_path_costs.push_back(total);
  endtask

  task automatic send_grid(input int unsigned count);
    repeat (count) send_cell(random_cost());
  endtask

  task automatic wait_for_results();
    cell_valid <= 1'b0;
    burst_left = 0;
    while (expected_path_costs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_one(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] value);
    wait_for_results();
    cfg_write <= 1'b1;
    cfg_addr  <= addr;
    cfg_data  <= value;
    @(posedge clk);
    apply_setting(addr, value);
    cfg_write <= 1'b0;
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] rows,
                           input logic [CFG_DATA_W-1:0] cols);
    write_one(REG_NUM_ROWS, rows);
    write_one(REG_NUM_COLS, cols);
  endtask

  // Reset sizes are 1x1, so every cell is a grid of its own.
  task automatic test_corner_cell();
    send_cell('0);
    send_cell('1);
    send_cell(16'd1);
  endtask

  task automatic test_zero_size();
    configure('0, '0);
    send_cell(16'h8000);
    send_cell(16'h7FFF);
  endtask

  task automatic test_line_grids();
    configure(11'd1, 11'd3);
    send_cell('1);
    send_cell('0);
    send_cell('1);
    configure(11'd3, 11'd1);
    send_cell('0);
    send_cell('1);
    send_cell(16'd1);
  endtask

  task automatic test_diagonal_grid();
    logic [CELL_COST_W-1:0] costs [9] = '{16'd1, 16'd9, 16'd9, 16'd9, 16'd1,
                                          16'd9, 16'd9, 16'd9, 16'd1};
    configure(11'd3, 11'd3);
    foreach (costs[k]) send_cell(costs[k]);
  endtask

  // A size write in mid-grid drops the partial grid.
  task automatic test_restart_on_write();
    configure(11'd2, 11'd3);
    send_cell(16'd7);
    send_cell(16'd8);
    write_one(REG_NUM_COLS, 11'd2);
    send_cell(16'd5);
    send_cell('1);
    send_cell('1);
    send_cell(16'd3);
  endtask

  task automatic test_largest_grids();
    configure(11'd1, 11'd1025);
    send_grid(cells_per_grid());
  endtask

  task automatic test_output_backpressure();
    gaps_on = 1'b0;
    configure(11'd1, 11'd1);
    hold_request = 300;
    send_grid(30);
    wait_for_results();
    configure(11'd2, 11'd3);
    hold_request = 200;
    send_grid(10 * cells_per_grid());
    wait_for_results();
    gaps_on = 1'b1;
  endtask

  task automatic test_random_grids();
    int unsigned start_count;
    int unsigned cells;
    start_count = cells_sent;
    while (cells_sent - start_count < RANDOM_CELLS) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      configure(random_extent(), random_extent());
      repeat ($urandom_range(1, 4)) send_grid(cells_per_grid());
      if ($urandom_range(0, 5) == 0) begin
        cells = cells_per_grid();
        if (cells > 1) send_grid($urandom_range(1, cells - 1));
        write_one($urandom_range(0, 1) ? REG_NUM_ROWS : REG_NUM_COLS, random_extent());
        send_grid(cells_per_grid());
      end else if ($urandom_range(0, 3) == 0) begin
        wait_for_results();
      end
    end
    gaps_on = 1'b1;
  endtask

  // Result checking and output stall pattern
  always @(posedge clk) begin
    if (!rst && path_valid === 1'b1 && path_stall === 1'b0) begin
      if (expected_path_costs.size() == 0) begin
        $error("path_cost: unexpected result %0d", path_cost);
        fails++;
      end else if (path_cost !== expected_path_costs[0]) begin
        $error("path_cost: expected %0d, got %0d", expected_path_costs[0], path_cost);
        fails++;
        void'(expected_path_costs.pop_front());
      end else begin
        void'(expected_path_costs.pop_front());
      end
    end
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (stall_mode_left == 0) begin
      stall_mode      = $urandom_range(0, 3);
      stall_mode_left = $urandom_range(32, 256);
    end else begin
      stall_mode_left--;
    end
    if (hold_left != 0) begin
      hold_left--;
      path_stall <= 1'b1;
    end else begin
      path_stall <= ($urandom_range(0, 3) < stall_mode);
    end
  end

  initial begin
    rst             = 1'b1;
    cfg_write       = 1'b0;
    cfg_addr        = '0;
    cfg_data        = '0;
    cell_valid      = 1'b0;
    cell_cost       = '0;
    fails           = 0;
    cells_sent      = 0;
    burst_left      = 0;
    gaps_on         = 1'b1;
    hold_request    = 0;
    hold_left       = 0;
    stall_mode      = 0;
    stall_mode_left = 0;
    foreach (row_sums[k]) row_sums[k] = '0;
    restart_grid();
    rows_setting = 11'd1;
    cols_setting = 11'd1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_corner_cell();
    test_zero_size();
    test_line_grids();
    test_diagonal_grid();
    test_restart_on_write();
    test_output_backpressure();
    test_largest_grids();
    test_random_grids();

    wait_for_results();
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
